### rtl/suk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suk_pkg: shared definitions for the sorted unique-key table
// Field widths, command and status codes, and the cell entry and control types.
// ----------------------------------------------------------------------------
package suk_pkg;

    localparam int TABLE_DEPTH = 16;

    localparam int KEY_W    = 16;
    localparam int YEAR_W   = 12;
    localparam int TITLE_W  = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_DUP     = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_MISSING = 3'd3,
        STAT_EMPTY   = 3'd4
    } status_t;

    // Action broadcast to every cell in the execute cycle.
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [YEAR_W-1:0]  year;
        logic [TITLE_W-1:0] title;
    } entry_t;

    typedef struct packed {
        op_t    op;
        entry_t ent;
    } cell_ctrl_t;

endpackage

### rtl/sorted_unique_key_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_key_table_top: bounded table sorted by year, unique keys
// Insert, remove by key and lookup by key over a row of shifting cells.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_*       in         tuser: cmd[1:0]; tdata: key_id, sort_year, title_handle
//  m_*       out        tuser: status[2:0]; tdata: found_year, found_title,
//                       entry_total
//
//  In the accept cycle every cell compares its key and registers a hit; in
//  the execute state, once any waiting result is taken, the cells shift with
//  their neighbors and the result is loaded into the output register.
//  Reset empties the table at once; there is no clearing pass.
//  A result waiting on m_tready stalls only the execute cycle of the next
//  transaction, which is already accepted.
// ----------------------------------------------------------------------------
module sorted_unique_key_table_top #(
    parameter int TABLE_DEPTH = suk_pkg::TABLE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key_id[15:0], sort_year[27:16], title_handle[59:28]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // found_year[11:0], found_title[43:12], entry_total[48:44]
    output logic [2:0]  m_tuser    // status[2:0]
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [suk_pkg::CMD_W-1:0]       cmd_reg;
    suk_pkg::entry_t                 op_ent_reg;
    logic                            out_valid_reg, out_valid_next;
    suk_pkg::status_t                status_reg, status_next;
    logic [suk_pkg::YEAR_W-1:0]      fyear_reg, fyear_next;
    logic [suk_pkg::TITLE_W-1:0]     ftitle_reg, ftitle_next;
    logic [suk_pkg::TOTAL_W-1:0]     total_reg;

    logic                            in_accept;
    logic                            fire;
    suk_pkg::cell_ctrl_t             ctrl;
    suk_pkg::entry_t                 cell_ent [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]          cell_ge;
    logic [TABLE_DEPTH-1:0]          cell_hit;
    logic [IDX_W-1:0]                hit_idx;
    logic                            any_hit;
    logic [suk_pkg::YEAR_W-1:0]      hit_year;
    logic [suk_pkg::TITLE_W-1:0]     hit_title;
    logic                            table_full;
    logic                            table_empty;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign fire      = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    assign table_full  = (count_reg == CNT_W'(TABLE_DEPTH));
    assign table_empty = (count_reg == '0);

    // Keys are unique, so at most one hit bit is set and OR-ing the masked
    // indexes and payloads yields the hit entry.
    always_comb
    begin
        hit_idx   = '0;
        hit_year  = '0;
        hit_title = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (cell_hit[i])
            begin
                hit_idx   = hit_idx | IDX_W'(i);
                hit_year  = hit_year | cell_ent[i].year;
                hit_title = hit_title | cell_ent[i].title;
            end
        end
    end

    assign any_hit = |cell_hit;

    always_comb
    begin
        ctrl.ent    = op_ent_reg;
        ctrl.op     = suk_pkg::OP_HOLD;
        status_next = suk_pkg::STAT_OK;
        fyear_next  = '0;
        ftitle_next = '0;
        count_next  = count_reg;
        case (cmd_reg)
            suk_pkg::CMD_INSERT:
            begin
                if (any_hit)
                begin
                    status_next = suk_pkg::STAT_DUP;
                end
                else if (table_full)
                begin
                    status_next = suk_pkg::STAT_FULL;
                end
                else
                begin
                    ctrl.op    = suk_pkg::OP_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            suk_pkg::CMD_REMOVE:
            begin
                if (table_empty)
                begin
                    status_next = suk_pkg::STAT_EMPTY;
                end
                else if (!any_hit)
                begin
                    status_next = suk_pkg::STAT_MISSING;
                end
                else
                begin
                    ctrl.op    = suk_pkg::OP_REMOVE;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            suk_pkg::CMD_LOOKUP:
            begin
                if (any_hit)
                begin
                    fyear_next  = hit_year;
                    ftitle_next = hit_title;
                end
                else
                begin
                    status_next = suk_pkg::STAT_MISSING;
                end
            end
            default:
            begin
                status_next = suk_pkg::STAT_OK;
            end
        endcase
        if (!fire)
        begin
            ctrl.op    = suk_pkg::OP_HOLD;
            count_next = count_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            suk_pkg::entry_t left_ent;
            logic            left_ge;
            suk_pkg::entry_t right_ent;

            if (g == 0)
            begin : g_first
                assign left_ent = op_ent_reg;
                assign left_ge  = 1'b0;
            end
            else
            begin : g_mid
                assign left_ent = cell_ent[g-1];
                assign left_ge  = cell_ge[g-1];
            end

            if (g == TABLE_DEPTH - 1)
            begin : g_last
                assign right_ent = cell_ent[g];
            end
            else
            begin : g_inner
                assign right_ent = cell_ent[g+1];
            end

            suk_cell #(
                .TABLE_DEPTH (TABLE_DEPTH),
                .CELL_IDX    (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .count     (count_reg),
                .hit_load  (in_accept),
                .cmp_key   (s_tdata[15:0]),
                .hit_idx   (hit_idx),
                .ctrl      (ctrl),
                .left_ent  (left_ent),
                .left_ge   (left_ge),
                .right_ent (right_ent),
                .ent       (cell_ent[g]),
                .ge        (cell_ge[g]),
                .hit       (cell_hit[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg          <= s_tuser;
            op_ent_reg.key   <= s_tdata[15:0];
            op_ent_reg.year  <= s_tdata[27:16];
            op_ent_reg.title <= s_tdata[59:28];
        end
        if (fire)
        begin
            status_reg <= status_next;
            fyear_reg  <= fyear_next;
            ftitle_reg <= ftitle_next;
            total_reg  <= suk_pkg::TOTAL_W'(count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, total_reg, ftitle_reg, fyear_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> $onehot0(cell_hit))
        else $error("more than one cell matched the key");

    a_refused_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (status_next != suk_pkg::STAT_OK)) |=> $stable(count_reg))
        else $error("refused transaction changed the entry count");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (ctrl.op == suk_pkg::OP_INSERT))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted insert did not add one entry");
`endif

endmodule

### rtl/suk_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suk_cell: one slot of the sorted table
// Holds one entry, flags a key hit, and shifts with its neighbors on an
// insert or a remove.
// ----------------------------------------------------------------------------
module suk_cell #(
    parameter int TABLE_DEPTH = suk_pkg::TABLE_DEPTH,
    parameter int CELL_IDX    = 0
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]   count,
    input  logic                               hit_load,
    input  logic [suk_pkg::KEY_W-1:0]          cmp_key,
    input  logic [$clog2(TABLE_DEPTH)-1:0]     hit_idx,
    input  suk_pkg::cell_ctrl_t                ctrl,
    input  suk_pkg::entry_t                    left_ent,
    input  logic                               left_ge,
    input  suk_pkg::entry_t                    right_ent,
    output suk_pkg::entry_t                    ent,
    output logic                               ge,
    output logic                               hit
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    suk_pkg::entry_t ent_reg;
    suk_pkg::entry_t ent_next;
    logic            hit_reg;
    logic            hit_next;
    logic            occupied;

    assign occupied = CNT_W'(CELL_IDX) < count;

    // An empty slot counts as "greater or equal" so the first empty slot
    // after the last smaller year takes the new entry.
    assign ge  = !occupied || (ent_reg.year >= ctrl.ent.year);
    assign ent = ent_reg;
    assign hit = hit_reg;

    always_comb
    begin
        hit_next = hit_reg;
        if (hit_load)
        begin
            hit_next = occupied && (ent_reg.key == cmp_key);
        end
    end

    always_comb
    begin
        ent_next = ent_reg;
        case (ctrl.op)
            suk_pkg::OP_INSERT:
            begin
                if (ge && !left_ge)
                begin
                    ent_next = ctrl.ent;
                end
                else if (ge)
                begin
                    ent_next = left_ent;
                end
            end
            suk_pkg::OP_REMOVE:
            begin
                if (IDX_W'(CELL_IDX) >= hit_idx)
                begin
                    ent_next = right_ent;
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule
